>>> hw/rtl/arm_data_processing_alu_core_macros.svh
// Assertion macros shared by the checker
`ifndef ARM_DATA_PROCESSING_ALU_CORE_MACROS_SVH
`define ARM_DATA_PROCESSING_ALU_CORE_MACROS_SVH
// implication checked every clock outside reset
`define ADP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ADP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> hw/rtl/adp_pkg.sv
package adp_pkg;
	typedef enum logic [1:0] {
		CMD_EXEC  = 2'd0,
		CMD_WRREG = 2'd1,
		CMD_RDREG = 2'd2,
		CMD_WRFLG = 2'd3
	} cmd_t;

	localparam logic [3:0] PC_IDX = 4'd15;
	localparam logic [7:0] IMM_MASK = 8'hFF;
	localparam logic [31:0] PC_AHEAD = 32'd4;

	localparam logic [3:0] OP_AND = 4'd0, OP_EOR = 4'd1, OP_SUB = 4'd2, OP_RSB = 4'd3;
	localparam logic [3:0] OP_ADD = 4'd4, OP_ADC = 4'd5, OP_SBC = 4'd6, OP_RSC = 4'd7;
	localparam logic [3:0] OP_TST = 4'd8, OP_TEQ = 4'd9, OP_CMP = 4'd10, OP_CMN = 4'd11;
	localparam logic [3:0] OP_ORR = 4'd12, OP_MOV = 4'd13, OP_BIC = 4'd14, OP_MVN = 4'd15;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] instruction;
		logic [3:0]  reg_index;
		logic [31:0] reg_value;
		logic [3:0]  flags_value;
	} item_t;

	// classified item placed in the queue
	typedef struct packed {
		item_t item;
		logic  test;
		logic  logical;
		logic  fen;
		logic  imm_op;
		logic  reg_shift;
	} dec_t;

	typedef struct packed {
		logic [31:0] result_value;
		logic [3:0]  dest_index;
		logic        dest_written;
		logic [3:0]  flags_out;
		logic        pc_written;
	} res_t;
endpackage

>>> hw/rtl/adp_front.sv
module adp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  adp_pkg::item_t   in_item,
	output logic             q_valid,
	input  logic             q_stall,
	output adp_pkg::dec_t    q_data
);
	// two-entry queue
	adp_pkg::dec_t mem_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	adp_pkg::dec_t dec;
	logic [3:0]    op;
	logic          push, pop;

	always_comb begin
		op = in_item.instruction[24:21];
		dec.item = in_item;
		dec.test = (op == adp_pkg::OP_TST) || (op == adp_pkg::OP_TEQ) ||
			(op == adp_pkg::OP_CMP) || (op == adp_pkg::OP_CMN);
		dec.logical = !(op >= adp_pkg::OP_SUB && op <= adp_pkg::OP_CMN) ||
			(op == adp_pkg::OP_TST) || (op == adp_pkg::OP_TEQ);
		dec.fen = in_item.instruction[20] && (in_item.instruction[15:12] != adp_pkg::PC_IDX);
		dec.imm_op = in_item.instruction[25];
		dec.reg_shift = !in_item.instruction[25] && in_item.instruction[4];
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && !q_stall;
	assign q_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

>>> hw/rtl/adp_back.sv
module adp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_stall,
	input  adp_pkg::dec_t   q_data,
	output logic            out_valid,
	input  logic            out_stall,
	output adp_pkg::res_t   out_res
);
	logic [31:0] rf_q [16];
	logic [3:0]  flags_q;
	logic        ov_q;
	adp_pkg::res_t res_q, res;
	logic        go;

	logic [31:0] ins, a, b, rm_v, sh, r;
	logic [3:0]  rd, rn, rm, op, nf;
	logic [1:0]  typ;
	logic [7:0]  amt;
	logic [4:0]  rot;
	logic        cin, sc, co, ov, fn, fz, fc, fv;
	logic [32:0] sum;
	logic [31:0] ax, bx;
	logic        cx;
	logic [63:0] dbl;

	assign q_stall = ov_q && out_stall;
	assign go = q_valid && !q_stall;
	assign out_valid = ov_q;
	assign out_res = res_q;

	always_comb begin
		ins = q_data.item.instruction;
		rd = ins[15:12];
		rn = ins[19:16];
		rm = ins[3:0];
		op = ins[24:21];
		typ = ins[6:5];
		cin = flags_q[1];
		a = rf_q[rn];
		rm_v = rf_q[rm];
		sc = cin;
		sh = rm_v;
		amt = 8'd0;
		rot = 5'd0;
		dbl = 64'd0;
		if (q_data.reg_shift) begin
			if (rn == adp_pkg::PC_IDX) a = a + adp_pkg::PC_AHEAD;
			if (rm == adp_pkg::PC_IDX) rm_v = rm_v + adp_pkg::PC_AHEAD;
			amt = rf_q[ins[11:8]][7:0];
		end else begin
			amt = {3'd0, ins[11:7]};
		end
		if (q_data.imm_op) begin
			rot = {ins[11:8], 1'b0};
			dbl = {24'd0, ins[7:0] & adp_pkg::IMM_MASK, 24'd0, ins[7:0]};
			sh = 32'(dbl >> rot);
			if (rot != 5'd0) sc = sh[31];
		end else if (!q_data.reg_shift && amt == 8'd0) begin
			unique case (typ)
				2'd0: sh = rm_v;
				2'd1: begin sh = 32'd0; sc = rm_v[31]; end
				2'd2: begin sh = {32{rm_v[31]}}; sc = rm_v[31]; end
				default: begin sh = {cin, rm_v[31:1]}; sc = rm_v[0]; end
			endcase
		end else if (amt == 8'd0) begin
			sh = rm_v;
		end else begin
			unique case (typ)
				2'd0: begin
					if (amt < 8'd32) begin
						sh = rm_v << amt[4:0];
						// 32 - amt, wrapped to five bits
						sc = rm_v[5'd0 - amt[4:0]];
					end else begin
						sh = 32'd0;
						sc = (amt == 8'd32) ? rm_v[0] : 1'b0;
					end
				end
				2'd1: begin
					if (amt < 8'd32) begin
						sh = rm_v >> amt[4:0];
						sc = rm_v[amt[4:0] - 5'd1];
					end else begin
						sh = 32'd0;
						sc = (amt == 8'd32) ? rm_v[31] : 1'b0;
					end
				end
				2'd2: begin
					if (amt < 8'd32) begin
						sh = 32'($signed(rm_v) >>> amt[4:0]);
						sc = rm_v[amt[4:0] - 5'd1];
					end else begin
						sh = {32{rm_v[31]}};
						sc = rm_v[31];
					end
				end
				default: begin
					dbl = {rm_v, rm_v};
					sh = 32'(dbl >> amt[4:0]);
					sc = rm_v[amt[4:0] - 5'd1];
				end
			endcase
		end
		b = sh;
		ax = a;
		bx = b;
		cx = 1'b0;
		case (op)
			adp_pkg::OP_SUB, adp_pkg::OP_CMP: begin bx = ~b; cx = 1'b1; end
			adp_pkg::OP_RSB: begin ax = b; bx = ~a; cx = 1'b1; end
			adp_pkg::OP_ADC: cx = cin;
			adp_pkg::OP_SBC: begin bx = ~b; cx = cin; end
			adp_pkg::OP_RSC: begin ax = b; bx = ~a; cx = cin; end
			default: ;
		endcase
		sum = {1'b0, ax} + {1'b0, bx} + {32'd0, cx};
		co = sum[32];
		ov = ~(ax[31] ^ bx[31]) & (ax[31] ^ sum[31]);
		case (op)
			adp_pkg::OP_AND, adp_pkg::OP_TST: r = a & b;
			adp_pkg::OP_EOR, adp_pkg::OP_TEQ: r = a ^ b;
			adp_pkg::OP_ORR: r = a | b;
			adp_pkg::OP_MOV: r = b;
			adp_pkg::OP_BIC: r = a & ~b;
			adp_pkg::OP_MVN: r = ~b;
			default: r = sum[31:0];
		endcase
		fn = flags_q[3];
		fz = flags_q[2];
		fc = flags_q[1];
		fv = flags_q[0];
		if (q_data.fen || q_data.test) begin
			fn = r[31];
			fz = (r == 32'd0);
			if (q_data.logical) begin
				if (q_data.fen) fc = sc;
			end else begin
				fc = co;
				fv = ov;
			end
		end
		nf = flags_q;
		res = '0;
		unique case (q_data.item.cmd)
			adp_pkg::CMD_EXEC: begin
				nf = {fn, fz, fc, fv};
				res.result_value = r;
				res.dest_index = rd;
				res.dest_written = !q_data.test;
				res.pc_written = !q_data.test && (rd == adp_pkg::PC_IDX);
			end
			adp_pkg::CMD_WRREG: begin
				res.result_value = q_data.item.reg_value;
				res.dest_index = q_data.item.reg_index;
				res.dest_written = 1'b1;
				res.pc_written = (q_data.item.reg_index == adp_pkg::PC_IDX);
			end
			adp_pkg::CMD_RDREG: begin
				res.result_value = rf_q[q_data.item.reg_index];
				res.dest_index = q_data.item.reg_index;
			end
			default: nf = q_data.item.flags_value;
		endcase
		res.flags_out = nf;
	end

	always_ff @(posedge clk) begin
		if (go) res_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) rf_q[i] <= 32'd0;
			flags_q <= 4'd0;
			ov_q <= 1'b0;
		end else begin
			if (go) begin
				flags_q <= nf;
				if (res.dest_written) rf_q[res.dest_index] <= res.result_value;
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end
endmodule

>>> hw/rtl/arm_data_processing_alu_core.sv
// ARMv4T data-processing execute unit with a 16x32 register file and NZCV flags.
// Input channel: in_valid/in_stall with cmd, instruction, reg_index, reg_value,
// flags_value. cmd selects execute, register write, register read or flag write.
// Output channel: out_valid/out_stall with result_value, dest_index,
// dest_written, flags_out and pc_written; one result per input transfer.
// A front stage classifies each instruction into a two-entry queue; the back
// stage reads operands, shifts, runs the ALU and registers the result.
// Each input is written into a queue entry, then its result into the output register.
// Throughput: one transfer per cycle while out_stall is low, set by the single-pass shifter and adder.
// When out_stall is held the output register keeps its result, the back
// stage stops, and the queue fills; in_stall rises once both entries are used.
// Reset clears the register file, the flags and all valid state.
module arm_data_processing_alu_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] instruction,
	input  logic [3:0]  reg_index,
	input  logic [31:0] reg_value,
	input  logic [3:0]  flags_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_value,
	output logic [3:0]  dest_index,
	output logic        dest_written,
	output logic [3:0]  flags_out,
	output logic        pc_written
);
	adp_pkg::item_t item;
	adp_pkg::dec_t  q_data;
	adp_pkg::res_t  res;
	logic           q_valid, q_stall;

	always_comb begin
		item.cmd = adp_pkg::cmd_t'(cmd);
		item.instruction = instruction;
		item.reg_index = reg_index;
		item.reg_value = reg_value;
		item.flags_value = flags_value;
	end

	adp_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_item(item),
		.q_valid, .q_stall, .q_data
	);

	adp_back u_back (
		.clk, .arst_n, .q_valid, .q_stall, .q_data,
		.out_valid, .out_stall, .out_res(res)
	);

	assign result_value = res.result_value;
	assign dest_index = res.dest_index;
	assign dest_written = res.dest_written;
	assign flags_out = res.flags_out;
	assign pc_written = res.pc_written;
endmodule

>>> hw/rtl/adp_checker.sv
`include "arm_data_processing_alu_core_macros.svh"
module adp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] result_value,
	input logic [3:0]  dest_index,
	input logic        dest_written,
	input logic        pc_written
);
	`ADP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result_value))
	`ADP_ASSERT_IMPL(a_pc_flag, out_valid && pc_written, dest_written && dest_index == adp_pkg::PC_IDX)
	// the queue only fills behind a held result
	`ADP_ASSERT_IMPL(a_full_held, in_valid && in_stall, out_valid)
	`ADP_ASSERT_NEXT(a_no_stall_idle, !out_valid, !in_stall)
endmodule

bind arm_data_processing_alu_core adp_checker u_adp_checker (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
	.result_value, .dest_index, .dest_written, .pc_written
);

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] instruction;
		logic [3:0]  reg_index;
		logic [31:0] reg_value;
		logic [3:0]  flags_value;
	} alu_req_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  cmd;
	logic [31:0] instruction;
	logic [3:0]  reg_index;
	logic [31:0] reg_value;
	logic [3:0]  flags_value;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] result_value;
	logic [3:0]  dest_index;
	logic        dest_written;
	logic [3:0]  flags_out;
	logic        pc_written;

	arm_data_processing_alu_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .instruction(instruction), .reg_index(reg_index),
		.reg_value(reg_value), .flags_value(flags_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_value(result_value), .dest_index(dest_index),
		.dest_written(dest_written), .flags_out(flags_out),
		.pc_written(pc_written)
	);

	alu_req_t      pending_reqs[$];
	adp_pkg::res_t expected_results[$];
	logic [31:0]   model_regs[16];
	logic [3:0]    model_nzcv;
	int            mismatches;
	int            send_idle_pct;
	int            recv_idle_pct;
	bit            hold_send;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [31:0] ror32(logic [31:0] v, int n);
		n = n & 31;
		return (n == 0) ? v : ((v >> n) | (v << (32 - n)));
	endfunction

	function automatic logic [31:0] asr_fill(logic [31:0] v, int n);
		if (n >= 32)
			return {32{v[31]}};
		return $signed(v) >>> n;
	endfunction

	// barrel shifter; imm_form applies the immediate-shift encodings for zero
	function automatic logic [31:0] barrel(logic [31:0] v, logic [1:0] kind, int amt,
			bit imm_form, logic cin, output logic cout);
		cout = cin;
		if (imm_form && amt == 0) begin
			case (kind)
				2'd0: return v;
				2'd1: begin cout = v[31]; return 32'd0; end
				2'd2: begin cout = v[31]; return {32{v[31]}}; end
				default: begin cout = v[0]; return {cin, v[31:1]}; end
			endcase
		end
		if (amt == 0)
			return v;
		case (kind)
			2'd0: begin
				if (amt < 32) begin cout = v[32 - amt]; return v << amt; end
				cout = (amt == 32) ? v[0] : 1'b0;
				return 32'd0;
			end
			2'd1: begin
				if (amt < 32) begin cout = v[amt - 1]; return v >> amt; end
				cout = (amt == 32) ? v[31] : 1'b0;
				return 32'd0;
			end
			2'd2: begin
				if (amt < 32) begin cout = v[amt - 1]; return asr_fill(v, amt); end
				cout = v[31];
				return {32{v[31]}};
			end
			default: begin
				if ((amt & 31) == 0) begin cout = v[31]; return v; end
				cout = v[(amt - 1) & 31];
				return ror32(v, amt);
			end
		endcase
	endfunction

	function automatic adp_pkg::res_t predict_alu(alu_req_t q);
		adp_pkg::res_t r;
		logic [31:0]   ins, a, b, y;
		logic [3:0]    op, rd, rn, rm;
		logic          n, z, c, v, sc, co, ov, fen, test, logical;
		logic [32:0]   sum;
		int            rot;
		r = '0;
		case (adp_pkg::cmd_t'(q.cmd))
			adp_pkg::CMD_EXEC: begin
				ins = q.instruction;
				op = ins[24:21];
				rd = ins[15:12];
				rn = ins[19:16];
				rm = ins[3:0];
				fen = ins[20] && rd != adp_pkg::PC_IDX;
				test = op inside {adp_pkg::OP_TST, adp_pkg::OP_TEQ, adp_pkg::OP_CMP,
					adp_pkg::OP_CMN};
				logical = !(op >= adp_pkg::OP_SUB && op <= adp_pkg::OP_CMN)
					|| op == adp_pkg::OP_TST || op == adp_pkg::OP_TEQ;
				{n, z, c, v} = model_nzcv;
				a = model_regs[rn];
				sc = c;
				if (ins[25]) begin
					rot = ins[11:8] * 2;
					b = ror32({24'd0, ins[7:0]}, rot);
					if (rot != 0)
						sc = b[31];
				end else begin
					b = model_regs[rm];
					if (ins[4]) begin
						if (rn == adp_pkg::PC_IDX) a = a + adp_pkg::PC_AHEAD;
						if (rm == adp_pkg::PC_IDX) b = b + adp_pkg::PC_AHEAD;
						b = barrel(b, ins[6:5], int'(model_regs[ins[11:8]][7:0]), 0, c, sc);
					end else begin
						b = barrel(b, ins[6:5], int'(ins[11:7]), 1, c, sc);
					end
				end
				co = c;
				ov = v;
				case (op)
					adp_pkg::OP_AND, adp_pkg::OP_TST: y = a & b;
					adp_pkg::OP_EOR, adp_pkg::OP_TEQ: y = a ^ b;
					adp_pkg::OP_SUB, adp_pkg::OP_CMP: sum = {1'b0, a} + {1'b0, ~b} + 33'd1;
					adp_pkg::OP_RSB: sum = {1'b0, b} + {1'b0, ~a} + 33'd1;
					adp_pkg::OP_ADD, adp_pkg::OP_CMN: sum = {1'b0, a} + {1'b0, b};
					adp_pkg::OP_ADC: sum = {1'b0, a} + {1'b0, b} + {32'd0, c};
					adp_pkg::OP_SBC: sum = {1'b0, a} + {1'b0, ~b} + {32'd0, c};
					adp_pkg::OP_RSC: sum = {1'b0, b} + {1'b0, ~a} + {32'd0, c};
					adp_pkg::OP_ORR: y = a | b;
					adp_pkg::OP_MOV: y = b;
					adp_pkg::OP_BIC: y = a & ~b;
					default: y = ~b;
				endcase
				if (!logical) begin
					y = sum[31:0];
					co = sum[32];
					case (op)
						adp_pkg::OP_RSB, adp_pkg::OP_RSC:
							ov = ~(b[31] ^ ~a[31]) & (b[31] ^ y[31]);
						adp_pkg::OP_SUB, adp_pkg::OP_CMP, adp_pkg::OP_SBC:
							ov = ~(a[31] ^ ~b[31]) & (a[31] ^ y[31]);
						default: ov = ~(a[31] ^ b[31]) & (a[31] ^ y[31]);
					endcase
				end
				if (fen || test) begin
					n = y[31];
					z = (y == 32'd0);
					if (logical) begin
						if (fen) c = sc;
					end else begin
						c = co;
						v = ov;
					end
					model_nzcv = {n, z, c, v};
				end
				if (!test)
					model_regs[rd] = y;
				r.result_value = y;
				r.dest_index = rd;
				r.dest_written = !test;
				r.pc_written = !test && rd == adp_pkg::PC_IDX;
			end
			adp_pkg::CMD_WRREG: begin
				model_regs[q.reg_index] = q.reg_value;
				r.result_value = q.reg_value;
				r.dest_index = q.reg_index;
				r.dest_written = 1'b1;
				r.pc_written = q.reg_index == adp_pkg::PC_IDX;
			end
			adp_pkg::CMD_RDREG: begin
				r.result_value = model_regs[q.reg_index];
				r.dest_index = q.reg_index;
			end
			default: model_nzcv = q.flags_value;
		endcase
		r.flags_out = model_nzcv;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cmd <= '0;
			instruction <= '0;
			reg_index <= '0;
			reg_value <= '0;
			flags_value <= '0;
		end else if (!(in_valid && in_stall)) begin
			if (pending_reqs.size() > 0 && !hold_send
					&& $urandom_range(99) >= send_idle_pct) begin
				alu_req_t q;
				q = pending_reqs.pop_front();
				expected_results.push_back(predict_alu(q));
				in_valid <= 1'b1;
				cmd <= q.cmd;
				instruction <= q.instruction;
				reg_index <= q.reg_index;
				reg_value <= q.reg_value;
				flags_value <= q.flags_value;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected transfer", result_value, 32'd0);
				end else begin
					adp_pkg::res_t e;
					e = expected_results.pop_front();
					if (result_value !== e.result_value)
						report_mismatch("result_value", result_value, e.result_value);
					if (dest_index !== e.dest_index)
						report_mismatch("dest_index", dest_index, e.dest_index);
					if (dest_written !== e.dest_written)
						report_mismatch("dest_written", dest_written, e.dest_written);
					if (flags_out !== e.flags_out)
						report_mismatch("flags_out", flags_out, e.flags_out);
					if (pc_written !== e.pc_written)
						report_mismatch("pc_written", pc_written, e.pc_written);
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	function automatic alu_req_t mk(adp_pkg::cmd_t c, logic [31:0] ins, logic [3:0] idx,
			logic [31:0] val, logic [3:0] fl);
		alu_req_t q;
		q.cmd = c;
		q.instruction = ins;
		q.reg_index = idx;
		q.reg_value = val;
		q.flags_value = fl;
		return q;
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(40);
			default: return $urandom;
		endcase
	endfunction

	function automatic alu_req_t random_req();
		logic [31:0] ins;
		int          k;
		k = $urandom_range(99);
		ins = $urandom;
		if (ins[25] == 1'b0 && ins[4] && $urandom_range(1))
			ins[7] = 1'b0;
		if (k < 70)
			return mk(adp_pkg::CMD_EXEC, ins, 4'($urandom), $urandom, 4'($urandom));
		if (k < 85)
			return mk(adp_pkg::CMD_WRREG, $urandom, 4'($urandom), pick_value(),
				4'($urandom));
		if (k < 93)
			return mk(adp_pkg::CMD_RDREG, $urandom, 4'($urandom), $urandom, 4'($urandom));
		return mk(adp_pkg::CMD_WRFLG, $urandom, 4'($urandom), $urandom, 4'($urandom));
	endfunction

	task automatic drain();
		while (pending_reqs.size() > 0 || expected_results.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		logic [31:0] ins;
		arst_n = 1'b0;
		mismatches = 0;
		hold_send = 0;
		send_idle_pct = 38;
		recv_idle_pct = 88;
		for (int i = 0; i < 16; i++)
			model_regs[i] = 32'd0;
		model_nzcv = 4'd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: operand extremes, every opcode, shifter corner encodings
		pending_reqs.push_back(mk(adp_pkg::CMD_WRREG, '0, 4'd1, 32'hFFFF_FFFF, '0));
		pending_reqs.push_back(mk(adp_pkg::CMD_WRREG, '0, 4'd2, 32'h8000_0001, '0));
		pending_reqs.push_back(mk(adp_pkg::CMD_WRREG, '0, 4'd3, 32'd33, '0));
		pending_reqs.push_back(mk(adp_pkg::CMD_WRREG, '0, adp_pkg::PC_IDX, 32'h7FFF_FFFC,
			'0));
		pending_reqs.push_back(mk(adp_pkg::CMD_WRFLG, '0, '0, '0, 4'hF));
		for (int op = 0; op < 16; op++) begin
			ins = 32'hE010_2002 | (op << 21) | (op[0] << 25);
			pending_reqs.push_back(mk(adp_pkg::CMD_EXEC, ins, '0, '0, '0));
		end
		pending_reqs.push_back(mk(adp_pkg::CMD_EXEC, 32'hE1B0_4022, '0, '0, '0)); // LSR #0
		pending_reqs.push_back(mk(adp_pkg::CMD_EXEC, 32'hE1B0_4062, '0, '0, '0)); // RRX
		// PC with reg shift
		pending_reqs.push_back(mk(adp_pkg::CMD_EXEC, 32'hE09F_4F3F, '0, '0, '0));
		// ASR by 33, Rd=PC
		pending_reqs.push_back(mk(adp_pkg::CMD_EXEC, 32'hE1B0_F351, '0, '0, '0));
		pending_reqs.push_back(mk(adp_pkg::CMD_RDREG, '0, adp_pkg::PC_IDX, '0, '0));
		// pause until every expected result is back
		while (pending_reqs.size() > 0)
			@(posedge clk);
		hold_send = 1;
		@(posedge clk);
		while (expected_results.size() > 0)
			@(posedge clk);
		hold_send = 0;

		for (int i = 0; i < 1700; i++) begin
			if (i == 570) begin
				drain();
				send_idle_pct = 88;
				recv_idle_pct = 38;
			end
			if (i == 1140) begin
				drain();
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			pending_reqs.push_back(random_req());
		end
		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end
endmodule
